// File: design/rfr_pkg.sv
// ----------------------------------------------------------------------------
// rfr_pkg
// Shared types and constants for the radius filter: widths, controller
// states and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rfr_pkg;

  localparam int CoordW    = 16;
  localparam int KindW     = 8;
  localparam int SumW      = 17;   // corner sum or twice a register
  localparam int ProdW     = 34;   // square of a 17-bit magnitude
  localparam int D4W       = 35;   // sum of two squares
  localparam int RadW      = 36;   // radicand padded to whole digit pairs
  localparam int RootW     = 18;
  localparam int RemW      = 18;
  localparam int DistW     = 17;
  localparam int IdxW      = 11;
  localparam int RootSteps = RadW / 2;
  localparam int StepW     = $clog2(RootSteps);
  localparam int AddrW     = 4;

  // register byte addresses divided by four
  localparam logic [1:0] REG_CENTER_X    = 2'd0;
  localparam logic [1:0] REG_CENTER_Z    = 2'd1;
  localparam logic [1:0] REG_RADIUS      = 2'd2;
  localparam logic [1:0] REG_TYPE_FILTER = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQZ,
    ST_SQR,
    ST_CMP,
    ST_ROOT,
    ST_MATCH,
    ST_END
  } state_t;

  typedef enum logic [1:0] {
    MUL_X,
    MUL_Z,
    MUL_R
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sum_en;
    logic     root_init;
    logic     root_step;
    logic     emit_match;
    logic     emit_end;
  } dp_cmd_t;

  typedef struct packed {
    logic type_ok;
    logic in_range;
    logic last;
    logic root_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: design/rfr_ctrl.sv
// ----------------------------------------------------------------------------
// rfr_ctrl
// Sequencer for one rectangle: three squares, compare, root steps and emit for a kept one, end marker after the last.
// ----------------------------------------------------------------------------
`default_nettype none

module rfr_ctrl
  import rfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_X;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SQX;
        end
      end
      ST_SQX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_X;
        state_nxt   = ST_SQZ;
      end
      ST_SQZ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Z;
        state_nxt   = ST_SQR;
      end
      ST_SQR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_R;
        cmd.sum_en  = 1'b1;
        state_nxt   = ST_CMP;
      end
      ST_CMP: begin
        if (status.type_ok && status.in_range) begin
          cmd.root_init = 1'b1;
          state_nxt     = ST_ROOT;
        end else if (status.last) begin
          state_nxt = ST_END;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) begin
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        if (status.out_free) begin
          cmd.emit_match = 1'b1;
          state_nxt      = status.last ? ST_END : ST_IDLE;
        end
      end
      ST_END: begin
        if (status.out_free) begin
          cmd.emit_end = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/rfr_dp.sv
// ----------------------------------------------------------------------------
// rfr_dp
// Datapath: item registers, shared squarer, digit-pair square root,
// match counter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rfr_dp
  import rfr_pkg::*;
#(
  parameter int MAX_MATCHES = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  output dp_status_t              status,
  input  wire logic [CoordW-1:0]  center_x,
  input  wire logic [CoordW-1:0]  center_z,
  input  wire logic [CoordW-1:0]  radius,
  input  wire logic [KindW-1:0]   type_filter,
  input  wire logic [CoordW-1:0]  corner_x1,
  input  wire logic [CoordW-1:0]  corner_z1,
  input  wire logic [CoordW-1:0]  corner_x2,
  input  wire logic [CoordW-1:0]  corner_z2,
  input  wire logic [KindW-1:0]   kind,
  input  wire logic               final_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [CoordW-1:0]       out_x1,
  output logic [CoordW-1:0]       out_z1,
  output logic [CoordW-1:0]       out_x2,
  output logic [CoordW-1:0]       out_z2,
  output logic [KindW-1:0]        out_kind,
  output logic [DistW-1:0]        distance,
  output logic [IdxW-1:0]         match_index,
  output logic                    end_marker
);

  localparam int CntW = $clog2(MAX_MATCHES + 1);

  // item registers
  logic [CoordW-1:0] x1_r, z1_r, x2_r, z2_r;
  logic [KindW-1:0]  kind_r;
  logic              last_r;
  logic              type_ok_r;
  logic [SumW-1:0]   sx_r, sz_r;

  // squares
  logic [D4W-1:0]    d4_r;
  logic [ProdW-1:0]  sq_r;
  logic [ProdW-1:0]  r4_r;
  logic [SumW-1:0]   two_cx, two_cz, two_r;
  logic [SumW-1:0]   mag;
  logic [ProdW-1:0]  prod;

  // root
  logic [RadW-1:0]   rad_r;
  logic [RemW-1:0]   rem_r;
  logic [RootW-1:0]  root_r;
  logic [StepW-1:0]  step_r;
  logic [RemW+1:0]   rem_pre;
  logic [RemW+1:0]   trial;
  logic              take;

  logic [CntW-1:0]   cnt_r;
  logic [CntW-1:0]   cnt_inc;

  logic              out_valid_r;
  logic [CoordW-1:0] ox1_r, oz1_r, ox2_r, oz2_r;
  logic [KindW-1:0]  okind_r;
  logic [DistW-1:0]  odist_r;
  logic [IdxW-1:0]   oidx_r;
  logic              oend_r;

  assign two_cx = {center_x, 1'b0};
  assign two_cz = {center_z, 1'b0};
  assign two_r  = {radius, 1'b0};

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_X:   mag = (sx_r >= two_cx) ? (sx_r - two_cx) : (two_cx - sx_r);
      MUL_Z:   mag = (sz_r >= two_cz) ? (sz_r - two_cz) : (two_cz - sz_r);
      MUL_R:   mag = two_r;
      default: mag = '0;
    endcase
  end

  assign prod = ProdW'(mag) * ProdW'(mag);

  // one digit pair of the radicand per step
  assign rem_pre = {rem_r, rad_r[RadW-1 -: 2]};
  assign trial   = {root_r, 2'b01};
  assign take    = (rem_pre >= trial);

  assign cnt_inc = (cnt_r < CntW'(MAX_MATCHES)) ? (cnt_r + CntW'(1)) : cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1_r      <= corner_x1;
      z1_r      <= corner_z1;
      x2_r      <= corner_x2;
      z2_r      <= corner_z2;
      kind_r    <= kind;
      last_r    <= final_item;
      type_ok_r <= (type_filter == '0) || (type_filter == kind);
      sx_r      <= SumW'(corner_x1) + SumW'(corner_x2);
      sz_r      <= SumW'(corner_z1) + SumW'(corner_z2);
    end
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        MUL_X:   d4_r <= D4W'(prod);
        MUL_Z:   sq_r <= prod;
        MUL_R:   r4_r <= prod;
        default: ;
      endcase
    end
    if (cmd.sum_en) begin
      d4_r <= d4_r + D4W'(sq_r);
    end
    if (cmd.root_init) begin
      rad_r  <= RadW'(d4_r);
      rem_r  <= '0;
      root_r <= '0;
      step_r <= StepW'(RootSteps - 1);
    end else if (cmd.root_step) begin
      rad_r  <= {rad_r[RadW-3:0], 2'b00};
      rem_r  <= take ? RemW'(rem_pre - trial) : RemW'(rem_pre);
      root_r <= {root_r[RootW-2:0], take};
      step_r <= step_r - StepW'(1);
    end
  end

  // match counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.emit_match) begin
      cnt_r <= cnt_inc;
    end else if (cmd.emit_end) begin
      cnt_r <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_match || cmd.emit_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // root is below 2^18, so half of it always fits the distance field
  always_ff @(posedge clk) begin
    if (cmd.emit_match) begin
      ox1_r   <= x1_r;
      oz1_r   <= z1_r;
      ox2_r   <= x2_r;
      oz2_r   <= z2_r;
      okind_r <= kind_r;
      odist_r <= root_r[RootW-1:1];
      oidx_r  <= IdxW'(cnt_inc);
      oend_r  <= 1'b0;
    end else if (cmd.emit_end) begin
      ox1_r   <= '0;
      oz1_r   <= '0;
      ox2_r   <= '0;
      oz2_r   <= '0;
      okind_r <= '0;
      odist_r <= '0;
      oidx_r  <= IdxW'(cnt_r);
      oend_r  <= 1'b1;
    end
  end

  assign status.type_ok   = type_ok_r;
  assign status.in_range  = (d4_r <= D4W'(r4_r));
  assign status.last      = last_r;
  assign status.root_last = (step_r == '0);
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_x1      = ox1_r;
  assign out_z1      = oz1_r;
  assign out_x2      = ox2_r;
  assign out_z2      = oz2_r;
  assign out_kind    = okind_r;
  assign distance    = odist_r;
  assign match_index = oidx_r;
  assign end_marker  = oend_r;

endmodule

`default_nettype wire

// File: design/radius_filter_rectangles.sv
// ----------------------------------------------------------------------------
// radius_filter_rectangles
// Keeps rectangles of the selected kind (all kinds if 0) whose center lies within a set radius
// of a query point, tags each with a running index and its distance, closes a list with a count.
// ----------------------------------------------------------------------------
// a dropped rectangle passes the states SQX, SQZ, SQR and CMP; a kept one
//   goes on through the 18-step square root (one digit pair per cycle) and
//   MATCH, which waits for a free output register; a new rectangle is taken
//   only back in IDLE, once the last one is through
// an end marker from state END follows the last rectangle of a list
// reset (synchronous, rst_n low): configuration registers, state and match count cleared, no output
`default_nettype none

module radius_filter_rectangles
  import rfr_pkg::*;
#(
  parameter int MAX_MATCHES = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input rectangles
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [63:0]      in_tdata,   // corner_x1, corner_z1, corner_x2, corner_z2
  input  wire logic [7:0]       in_tuser,   // kind
  input  wire logic             in_tlast,   // final_item
  // results
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [95:0]           out_tdata,  // out_x1, out_z1, out_x2, out_z2,
                                            // distance, match_index, zero pad
  output logic [7:0]            out_tuser,  // out_kind
  output logic                  out_tlast,  // end_marker
  // configuration
  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [AddrW-1:0] cfg_paddr,
  input  wire logic [31:0]      cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  // configuration registers
  logic [CoordW-1:0] center_x_r;
  logic [CoordW-1:0] center_z_r;
  logic [CoordW-1:0] radius_r;
  logic [KindW-1:0]  type_filter_r;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  dp_cmd_t    cmd;
  dp_status_t status;

  logic [CoordW-1:0] o_x1, o_z1, o_x2, o_z2;
  logic [KindW-1:0]  o_kind;
  logic [DistW-1:0]  o_dist;
  logic [IdxW-1:0]   o_idx;
  logic              o_end;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  // writes must land while the block is idle (not enforced); bits above a register's width drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= '0;
      center_z_r    <= '0;
      radius_r      <= '0;
      type_filter_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CENTER_X:    center_x_r    <= cfg_pwdata[CoordW-1:0];
        REG_CENTER_Z:    center_z_r    <= cfg_pwdata[CoordW-1:0];
        REG_RADIUS:      radius_r      <= cfg_pwdata[CoordW-1:0];
        REG_TYPE_FILTER: type_filter_r <= cfg_pwdata[KindW-1:0];
        default:         ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (cfg_idx)
      REG_CENTER_X:    cfg_prdata = 32'(center_x_r);
      REG_CENTER_Z:    cfg_prdata = 32'(center_z_r);
      REG_RADIUS:      cfg_prdata = 32'(radius_r);
      REG_TYPE_FILTER: cfg_prdata = 32'(type_filter_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // sequencer: accepts a rectangle only from idle
  rfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic, counter and output register
  rfr_dp #(
    .MAX_MATCHES (MAX_MATCHES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .center_x    (center_x_r),
    .center_z    (center_z_r),
    .radius      (radius_r),
    .type_filter (type_filter_r),
    .corner_x1   (in_tdata[15:0]),
    .corner_z1   (in_tdata[31:16]),
    .corner_x2   (in_tdata[47:32]),
    .corner_z2   (in_tdata[63:48]),
    .kind        (in_tuser),
    .final_item  (in_tlast),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_x1      (o_x1),
    .out_z1      (o_z1),
    .out_x2      (o_x2),
    .out_z2      (o_z2),
    .out_kind    (o_kind),
    .distance    (o_dist),
    .match_index (o_idx),
    .end_marker  (o_end)
  );

  // pack the result request
  assign out_tdata = {4'b0000, o_idx, o_dist, o_z2, o_x2, o_z1, o_x1};
  assign out_tuser = o_kind;
  assign out_tlast = o_end;

  // a new rectangle is never taken right after one was accepted
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted twice in a row");

  // the end marker carries only the count
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[80:0] == '0 && out_tuser == '0))
    else $error("end marker carries nonzero payload");

  // a kept rectangle lies within the radius
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[80:64] <= {1'b0, radius_r}))
    else $error("match distance exceeds radius");

endmodule

`default_nettype wire
